>>> rtl/core/piddf_pkg.sv
// piddf_pkg: shared constants for the PID controller core.
// Register map indexes, field widths and derivative filter constants.
// No dependencies.
package piddf_pkg;

  // Configuration port geometry
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Register field widths
  localparam int unsigned GAIN_W  = 16;
  localparam int unsigned LIMIT_W = 15;
  localparam int unsigned BAND_W  = 16;
  localparam int unsigned ALPHA_W = 9;

  // Shared multiplier: first operand is a gain or a filter weight
  localparam int unsigned MUL_A_W = GAIN_W + 1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_LIMIT      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_BAND  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_ALPHA    = 3'd7;

  // Derivative filter coefficient, Q1.8
  localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 9'd256;
  localparam logic [ALPHA_W-1:0] ALPHA_MIN   = 9'd3;
  localparam int unsigned        ALPHA_SHIFT = 8;

  // Register reset values
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'h7FFF;

endpackage

>>> rtl/core/pid_deadband_iband_dfilter_unit.sv
// PID controller core, one transaction in and one drive value out per sample.
// A new sample is taken only in idle, after the last drive value has gone to the
//   output register; a step makes five passes through the single shared multiplier
//   under the step sequencer, and a clear skips them.
// Reset: rst_ni async active low; registers to their defaults, state to zero.
// Depends on piddf_pkg.
module pid_deadband_iband_dfilter_unit
  import piddf_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 16,
  parameter int unsigned FRAC_BITS  = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration write channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [CFG_DATA_W-1:0]        cfg_data_i,
  // sample channel
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [DATA_WIDTH-1:0] measured_i,
  input  logic signed [DATA_WIDTH-1:0] target_i,
  input  logic                         command_i,
  // drive channel
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [DATA_WIDTH-1:0] drive_out_o
);

  // Datapath widths
  localparam int unsigned EW  = DATA_WIDTH + 1;             // error, measurement delta
  localparam int unsigned PRW = DATA_WIDTH + GAIN_W + 1;    // gain * error product
  localparam int unsigned WD  = DATA_WIDTH + GAIN_W + 2;    // raw and filtered derivative
  localparam int unsigned AW  = LIMIT_W + 1 + FRAC_BITS;    // integral accumulator
  localparam int unsigned IW  = ((AW > PRW) ? AW : PRW) + 1;
  localparam int unsigned PW  = MUL_A_W + WD;               // multiplier product
  localparam int unsigned TW  = WD + ALPHA_W + 1;           // filter sum
  localparam int unsigned SW  = ((WD > AW) ? WD : AW) + 2;  // P + I + D
  localparam int unsigned CW  = (EW > BAND_W) ? EW : BAND_W;

  localparam logic [DATA_WIDTH-1:0] DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};

  // Sequencer states
  localparam int unsigned ST_W = 4;
  localparam logic [ST_W-1:0] ST_IDLE = 4'd0;
  localparam logic [ST_W-1:0] ST_ERR  = 4'd1;
  localparam logic [ST_W-1:0] ST_MP   = 4'd2;
  localparam logic [ST_W-1:0] ST_MI   = 4'd3;
  localparam logic [ST_W-1:0] ST_MD   = 4'd4;
  localparam logic [ST_W-1:0] ST_RAW  = 4'd5;
  localparam logic [ST_W-1:0] ST_MA   = 4'd6;
  localparam logic [ST_W-1:0] ST_MB   = 4'd7;
  localparam logic [ST_W-1:0] ST_DF   = 4'd8;
  localparam logic [ST_W-1:0] ST_SUM  = 4'd9;
  localparam logic [ST_W-1:0] ST_OUT  = 4'd10;

  // Configuration registers
  logic signed [GAIN_W-1:0]  gain_p_q, gain_i_q, gain_d_q;
  logic [LIMIT_W-1:0]        out_limit_q, integral_limit_q;
  logic [BAND_W-1:0]         integral_band_q, dead_zone_q;
  logic [ALPHA_W-1:0]        deriv_alpha_q;

  // Control and controller state
  logic [ST_W-1:0]           state_q, state_d;
  logic                      out_valid_q;
  logic signed [AW-1:0]      acc_q;
  logic signed [DATA_WIDTH-1:0] prev_meas_q;
  logic signed [WD-1:0]      prev_deriv_q;

  // Datapath registers
  logic signed [DATA_WIDTH-1:0] meas_q, tgt_q, res_q, drive_q;
  logic                      cmd_q;
  logic signed [EW-1:0]      err_q, dm_q;
  logic                      int_en_q;
  logic signed [PRW-1:0]     p_q;
  logic signed [WD-1:0]      raw_q;
  logic signed [TW-1:0]      t_q;
  logic signed [PW-1:0]      prod_q;

  logic in_acc;
  logic out_free;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign drive_out_o = drive_q;

  // Register writes; all eight indexes are decoded
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q         <= '0;
      gain_i_q         <= '0;
      gain_d_q         <= '0;
      out_limit_q      <= LIMIT_RESET;
      integral_limit_q <= LIMIT_RESET;
      integral_band_q  <= '0;
      dead_zone_q      <= '0;
      deriv_alpha_q    <= ALPHA_ONE;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_GAIN_P:         gain_p_q         <= cfg_data_i[GAIN_W-1:0];
        REG_GAIN_I:         gain_i_q         <= cfg_data_i[GAIN_W-1:0];
        REG_GAIN_D:         gain_d_q         <= cfg_data_i[GAIN_W-1:0];
        REG_OUT_LIMIT:      out_limit_q      <= cfg_data_i[LIMIT_W-1:0];
        REG_INTEGRAL_LIMIT: integral_limit_q <= cfg_data_i[LIMIT_W-1:0];
        REG_INTEGRAL_BAND:  integral_band_q  <= cfg_data_i[BAND_W-1:0];
        REG_DEAD_ZONE:      dead_zone_q      <= cfg_data_i[BAND_W-1:0];
        REG_DERIV_ALPHA:    deriv_alpha_q    <= cfg_data_i[ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  // Error, dead zone and integration band
  logic signed [EW-1:0] err_raw, err_fin, dm_d;
  logic [EW-1:0]        err_mag, mag_fin;
  logic                 in_dz, int_en_d;

  always_comb begin
    err_raw  = {tgt_q[DATA_WIDTH-1], tgt_q} - {meas_q[DATA_WIDTH-1], meas_q};
    err_mag  = err_raw[EW-1] ? (~err_raw + 1'b1) : err_raw;
    in_dz    = CW'(err_mag) < CW'(dead_zone_q);
    err_fin  = in_dz ? '0 : err_raw;
    mag_fin  = in_dz ? '0 : err_mag;
    int_en_d = (integral_band_q == '0) || (CW'(mag_fin) < CW'(integral_band_q));
    dm_d     = {meas_q[DATA_WIDTH-1], meas_q} - {prev_meas_q[DATA_WIDTH-1], prev_meas_q};
  end

  // Filter coefficient held to its legal range
  logic [ALPHA_W-1:0] alpha_eff;
  always_comb begin
    priority if (deriv_alpha_q < ALPHA_MIN) alpha_eff = ALPHA_MIN;
    else if (deriv_alpha_q > ALPHA_ONE)     alpha_eff = ALPHA_ONE;
    else                                    alpha_eff = deriv_alpha_q;
  end

  // Shared multiplier operand select
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [WD-1:0]      mul_b;
  logic signed [PW-1:0]      prod_d;

  always_comb begin
    unique case (state_q)
      ST_MP: begin
        mul_a = MUL_A_W'(gain_p_q);
        mul_b = WD'(err_q);
      end
      ST_MI: begin
        mul_a = MUL_A_W'(gain_i_q);
        mul_b = WD'(err_q);
      end
      ST_MD: begin
        mul_a = MUL_A_W'(gain_d_q);
        mul_b = WD'(dm_q);
      end
      ST_MA: begin
        mul_a = MUL_A_W'(alpha_eff);
        mul_b = raw_q;
      end
      ST_MB: begin
        mul_a = MUL_A_W'(ALPHA_ONE - alpha_eff);
        mul_b = prev_deriv_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_d = mul_a * mul_b;
  end

  // Integral update with symmetric clamp
  logic signed [PRW-1:0] prod_gi;
  logic signed [IW-1:0]  acc_sum, int_lim, acc_clamped;

  always_comb begin
    prod_gi = prod_q[PRW-1:0];
    acc_sum = IW'(acc_q) + IW'(prod_gi);
    int_lim = IW'({integral_limit_q, {FRAC_BITS{1'b0}}});
    priority if (acc_sum > int_lim) acc_clamped = int_lim;
    else if (acc_sum < -int_lim)     acc_clamped = -int_lim;
    else                             acc_clamped = acc_sum;
  end

  // Derivative: negated product, then weighted blend with the last value
  logic signed [WD-1:0] prod_gd, raw_d;
  logic signed [TW-1:0] prod_t, t_sum;

  always_comb begin
    prod_gd = prod_q[WD-1:0];
    raw_d   = -prod_gd;
    prod_t  = prod_q[TW-1:0];
    t_sum   = t_q + prod_t;
  end

  // Output sum, scale back to integer units and clamp
  logic signed [SW-1:0] sum, sum_shr, lim_out, lim_cfg, lim_dat, res_d;

  always_comb begin
    sum     = SW'(p_q) + SW'(acc_q) + SW'(prev_deriv_q);
    sum_shr = sum >>> FRAC_BITS;
    lim_cfg = SW'(out_limit_q);
    lim_dat = SW'(DATA_MAX);
    lim_out = (lim_cfg < lim_dat) ? lim_cfg : lim_dat;
    priority if (sum_shr > lim_out) res_d = lim_out;
    else if (sum_shr < -lim_out)     res_d = -lim_out;
    else                             res_d = sum_shr;
  end

  // Step sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_ERR;
      ST_ERR:  state_d = cmd_q ? ST_OUT : ST_MP;
      ST_MP:   state_d = ST_MI;
      ST_MI:   state_d = ST_MD;
      ST_MD:   state_d = ST_RAW;
      ST_RAW:  state_d = ST_MA;
      ST_MA:   state_d = ST_MB;
      ST_MB:   state_d = ST_DF;
      ST_DF:   state_d = ST_SUM;
      ST_SUM:  state_d = ST_OUT;
      ST_OUT:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Control and controller state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      out_valid_q  <= 1'b0;
      acc_q        <= '0;
      prev_meas_q  <= '0;
      prev_deriv_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == ST_ERR && cmd_q) begin
        acc_q        <= '0;
        prev_meas_q  <= '0;
        prev_deriv_q <= '0;
      end
      if (state_q == ST_MD && int_en_q) begin
        acc_q <= acc_clamped[AW-1:0];
      end
      if (state_q == ST_DF) begin
        prev_deriv_q <= t_sum[ALPHA_SHIFT +: WD];
        prev_meas_q  <= meas_q;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (in_acc) begin
      meas_q <= measured_i;
      tgt_q  <= target_i;
      cmd_q  <= command_i;
    end
    if (state_q == ST_ERR) begin
      err_q    <= err_fin;
      dm_q     <= dm_d;
      int_en_q <= int_en_d;
      res_q    <= '0;
    end
    if (state_q == ST_MI) begin
      p_q <= prod_q[PRW-1:0];
    end
    if (state_q == ST_RAW) begin
      raw_q <= raw_d;
    end
    if (state_q == ST_MB) begin
      t_q <= prod_t;
    end
    if (state_q == ST_SUM) begin
      res_q <= res_d[DATA_WIDTH-1:0];
    end
    if (state_q == ST_OUT && out_free) begin
      drive_q <= res_q;
    end
  end

endmodule

>>> rtl/core/piddf_checker.sv
// piddf_checker: port-level checks for the PID controller core.
// Bound to pid_deadband_iband_dfilter_unit; watches the sample and drive handshakes only.
module piddf_checker #(
  parameter int unsigned DATA_WIDTH = 16
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic signed [DATA_WIDTH-1:0] drive_out_o
);

  localparam logic [DATA_WIDTH-1:0] DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  logic in_acc, out_acc;
  logic [1:0] outst_q;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  // Samples taken but whose drive value is not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outst_q <= 2'd0;
    end else begin
      outst_q <= outst_q + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  // A stalled drive value holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(drive_out_o))
    else $error("drive value changed or dropped while stalled");

  // One sample in work at a time
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o)
    else $error("ready again right after a sample transaction");

  // Clamp never reaches the most negative code
  a_clamp_sym: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> drive_out_o != DATA_MIN)
    else $error("drive value outside symmetric range");

  // No drive value without a sample behind it
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> outst_q != 2'd0)
    else $error("drive value with no pending sample");

  // At most one finished and one working sample
  a_outst_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    outst_q != 2'd3)
    else $error("too many samples outstanding");

endmodule

bind pid_deadband_iband_dfilter_unit piddf_checker #(
  .DATA_WIDTH(DATA_WIDTH)
) u_piddf_checker (.*);

>>> verif/tb.sv
// tb: self-checking bench for pid_deadband_iband_dfilter_unit.
// A queue-fed driver, a response monitor and a transaction-level PID predictor check every drive value.
// Depends on piddf_pkg and the unit RTL.
`timescale 1ns / 100ps

module tb;
  import piddf_pkg::*;

  localparam int DATA_W      = 16;
  localparam int FRAC_W      = 8;
  localparam int RAND_PHASES = 13;
  localparam int PHASE_ITEMS = 100;
  localparam int CYCLE_LIMIT = 500000;

  typedef enum logic {
    CMD_STEP  = 1'b0,
    CMD_CLEAR = 1'b1
  } pid_cmd_e;

  typedef logic signed [DATA_W-1:0] sample_val_t;

  typedef struct packed {
    sample_val_t measured;
    sample_val_t target;
    pid_cmd_e    cmd;
  } sample_t;

  typedef struct {
    logic signed [GAIN_W-1:0] kp;
    logic signed [GAIN_W-1:0] ki;
    logic signed [GAIN_W-1:0] kd;
    logic [LIMIT_W-1:0]       out_lim;
    logic [LIMIT_W-1:0]       int_lim;
    logic [BAND_W-1:0]        band;
    logic [BAND_W-1:0]        dead;
    logic [ALPHA_W-1:0]       alpha;
  } pid_regs_t;

  // DUT ports, all inputs known from time zero
  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  sample_val_t           measured_i  = '0;
  sample_val_t           target_i    = '0;
  logic                  command_i   = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  sample_val_t           drive_out_o;

  // predictor copy of registers and controller state
  pid_regs_t regs = '{'0, '0, '0, LIMIT_RESET, LIMIT_RESET, '0, '0, ALPHA_ONE};
  longint    integ_acc  = 0;
  longint    last_meas  = 0;
  longint    last_dterm = 0;

  sample_t     pending_samples[$];
  sample_val_t expected_drive[$];

  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  logic        rx_hold     = 1'b0;
  logic        in_taken    = 1'b0;
  int          walk_meas   = 0;
  int          walk_target = 0;
  int unsigned samples_in    = 0;
  int unsigned clears_in     = 0;
  int unsigned drives_seen   = 0;
  int unsigned input_stalls  = 0;
  int unsigned mismatches    = 0;
  int unsigned reg_settings  = 1;
  int unsigned cycle_count   = 0;

  pid_deadband_iband_dfilter_unit #(
    .DATA_WIDTH(DATA_W),
    .FRAC_BITS (FRAC_W)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .measured_i (measured_i),
    .target_i   (target_i),
    .command_i  (command_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .drive_out_o(drive_out_o)
  );

  always #6 clk_i = ~clk_i;

  // Register write as the block decodes it
  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_GAIN_P:         regs.kp      = data;
      REG_GAIN_I:         regs.ki      = data;
      REG_GAIN_D:         regs.kd      = data;
      REG_OUT_LIMIT:      regs.out_lim = data[LIMIT_W-1:0];
      REG_INTEGRAL_LIMIT: regs.int_lim = data[LIMIT_W-1:0];
      REG_INTEGRAL_BAND:  regs.band    = data[BAND_W-1:0];
      REG_DEAD_ZONE:      regs.dead    = data[BAND_W-1:0];
      REG_DERIV_ALPHA:    regs.alpha   = data[ALPHA_W-1:0];
      default: ;
    endcase
  endfunction

  // One controller step: dead zone, P, banded and clamped I, filtered D on measurement; a clear resets the state
  function automatic sample_val_t pid_next(input sample_t s);
    longint meas, err, mag, p_term, raw, d_term, sum, res, lim;
    longint kp, ki, kd, dz, band, a, a_one, a_min;
    if (s.cmd == CMD_CLEAR) begin
      integ_acc  = 0;
      last_meas  = 0;
      last_dterm = 0;
      return '0;
    end
    kp    = regs.kp;
    ki    = regs.ki;
    kd    = regs.kd;
    dz    = regs.dead;
    band  = regs.band;
    a     = regs.alpha;
    a_one = ALPHA_ONE;
    a_min = ALPHA_MIN;
    meas  = s.measured;
    err   = longint'(s.target) - meas;
    mag   = (err < 0) ? -err : err;
    if (mag < dz) begin
      err = 0;
      mag = 0;
    end
    p_term = kp * err;
    // integral only inside the band; held (not re-clamped) outside it
    if (band == 0 || mag < band) begin
      lim = regs.int_lim;
      lim = lim <<< FRAC_W;
      integ_acc = integ_acc + ki * err;
      if (integ_acc > lim) integ_acc = lim;
      else if (integ_acc < -lim) integ_acc = -lim;
    end
    if (a < a_min) a = a_min;
    if (a > a_one) a = a_one;
    raw    = -(kd * (meas - last_meas));
    d_term = (a * raw + (a_one - a) * last_dterm) >>> ALPHA_SHIFT;
    sum    = p_term + integ_acc + d_term;
    res    = sum >>> FRAC_W;
    lim    = regs.out_lim;
    if (res > lim) res = lim;
    else if (res < -lim) res = -lim;
    lim = (longint'(1) <<< (DATA_W - 1)) - 1;
    if (res > lim) res = lim;
    else if (res < -lim) res = -lim;
    last_meas  = meas;
    last_dterm = d_term;
    return DATA_W'(res);
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 30) $display("[%0t] MISMATCH: %s", $time, what);
  endtask

  // One config transaction; returns at a rising edge
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [15:0] kp, ki, kd, ol, il, band, dz, alpha);
    write_reg(REG_GAIN_P, kp);
    write_reg(REG_GAIN_I, ki);
    write_reg(REG_GAIN_D, kd);
    write_reg(REG_OUT_LIMIT, ol);
    write_reg(REG_INTEGRAL_LIMIT, il);
    write_reg(REG_INTEGRAL_BAND, band);
    write_reg(REG_DEAD_ZONE, dz);
    write_reg(REG_DERIV_ALPHA, alpha);
    reg_settings++;
  endtask

  function automatic void push_sample(input int meas, input int tgt, input pid_cmd_e cmd);
    sample_t s;
    s.measured = DATA_W'(meas);
    s.target   = DATA_W'(tgt);
    s.cmd      = cmd;
    pending_samples.push_back(s);
  endfunction

  // Block is idle once every sample is in and every drive value is back
  task automatic wait_idle();
    while (pending_samples.size() != 0 || in_valid_i || expected_drive.size() != 0)
      @(posedge clk_i);
  endtask

  function automatic sample_val_t extreme_val();
    case ($urandom_range(3))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  // Mostly a plant-like walk toward the setpoint, some full-range noise and extremes
  function automatic sample_t rand_sample();
    sample_t s;
    int unsigned pick;
    pick  = $urandom_range(99);
    s.cmd = (pick < 4) ? CMD_CLEAR : CMD_STEP;
    if (pick < 35) begin
      s.measured = DATA_W'($urandom);
      s.target   = DATA_W'($urandom);
    end else if (pick < 92) begin
      if ($urandom_range(24) == 0) walk_target = int'($urandom_range(6000)) - 3000;
      walk_meas += (walk_target - walk_meas) / 6 + int'($urandom_range(300)) - 150;
      if (walk_meas > 32767) walk_meas = 32767;
      if (walk_meas < -32768) walk_meas = -32768;
      s.measured = DATA_W'(walk_meas);
      s.target   = DATA_W'(walk_target);
    end else begin
      s.measured = extreme_val();
      s.target   = extreme_val();
    end
    return s;
  endfunction

  function automatic logic [15:0] rand_gain();
    logic [15:0] g;
    if ($urandom_range(9) < 3) return 16'($urandom);
    g = 16'($urandom_range(1023));
    if ($urandom_range(1) == 1) g = -g;
    return g;
  endfunction

  function automatic logic [15:0] rand_limit();
    if ($urandom_range(9) < 3) return 16'($urandom);
    return 16'($urandom_range(2000));
  endfunction

  function automatic logic [15:0] rand_band();
    case ($urandom_range(9))
      0, 1, 2, 3: return '0;
      4, 5, 6:    return 16'($urandom_range(3000));
      default:    return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_dead();
    int unsigned pick;
    pick = $urandom_range(19);
    if (pick < 10) return '0;
    if (pick < 17) return 16'($urandom_range(100));
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] rand_alpha();
    if ($urandom_range(19) < 3) return 16'($urandom);
    return 16'($urandom_range(256, 3));
  endfunction

  // Sample driver: next transaction at the falling edge, random gaps on both sides
  always @(negedge clk_i) begin
    sample_t nxt;
    logic    offer;
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        offer = pending_samples.size() != 0 && $urandom_range(99) >= tx_idle_pct;
        if (offer) begin
          nxt = pending_samples.pop_front();
          measured_i <= nxt.measured;
          target_i   <= nxt.target;
          command_i  <= nxt.cmd;
        end
        in_valid_i <= offer;
      end
      out_ready_i <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Monitor: predict on input transactions, check drive transactions in order
  always @(posedge clk_i) begin
    sample_t     cur;
    sample_val_t want;
    if (!rst_ni) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid_i && in_ready_o;
      if (in_valid_i && !in_ready_o) input_stalls++;
      if (in_valid_i && in_ready_o) begin
        cur.measured = measured_i;
        cur.target   = target_i;
        cur.cmd      = pid_cmd_e'(command_i);
        expected_drive.push_back(pid_next(cur));
        samples_in++;
        if (cur.cmd == CMD_CLEAR) clears_in++;
      end
      if (out_valid_o && out_ready_i) begin
        drives_seen++;
        if (expected_drive.size() == 0) begin
          report_mismatch($sformatf("drive_out %0d with no sample outstanding", drive_out_o));
        end else begin
          want = expected_drive.pop_front();
          if (drive_out_o !== want)
            report_mismatch($sformatf("drive %0d: drive_out got %0d, want %0d",
                                      drives_seen, drive_out_o, want));
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Long drain hold-off mid-run so the unit backs up and stalls its input
  initial begin
    while (!(samples_in >= 620 && pending_samples.size() > 40)) @(posedge clk_i);
    rx_hold = 1'b1;
    repeat (400) @(posedge clk_i);
    rx_hold = 1'b0;
  end

  // Main sequence
  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // reset defaults: zero gains give zero drive
    push_sample(0, 0, CMD_STEP);
    push_sample(-32768, 32767, CMD_STEP);
    push_sample(32767, -32768, CMD_STEP);
    wait_idle();

    // extreme gains, full-scale errors, clear in the middle
    program_regs(16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0000, 16'h0000,
                 16'h0100);
    push_sample(-32768, 32767, CMD_STEP);
    push_sample(32767, -32768, CMD_STEP);
    push_sample(0, 0, CMD_STEP);
    push_sample(123, 456, CMD_CLEAR);
    push_sample(100, -100, CMD_STEP);
    wait_idle();

    // zero output and integral limits
    write_reg(REG_GAIN_P, 16'h0100);
    write_reg(REG_GAIN_I, 16'h0100);
    write_reg(REG_GAIN_D, 16'h8000);
    write_reg(REG_OUT_LIMIT, 16'h0000);
    write_reg(REG_INTEGRAL_LIMIT, 16'h0000);
    reg_settings++;
    push_sample(5, 9, CMD_STEP);
    push_sample(-300, 300, CMD_STEP);
    wait_idle();

    // dead zone and band edges, alpha below minimum
    write_reg(REG_OUT_LIMIT, 16'h7FFF);
    write_reg(REG_INTEGRAL_LIMIT, 16'd200);
    write_reg(REG_INTEGRAL_BAND, 16'd1000);
    write_reg(REG_DEAD_ZONE, 16'd50);
    write_reg(REG_DERIV_ALPHA, 16'd0);
    reg_settings++;
    push_sample(0, 30, CMD_STEP);
    push_sample(0, -50, CMD_STEP);
    push_sample(0, 999, CMD_STEP);
    push_sample(0, 1000, CMD_STEP);
    push_sample(0, -999, CMD_STEP);
    wait_idle();

    // lowered integral limit: held outside band, re-clamped inside; alpha above one
    write_reg(REG_INTEGRAL_LIMIT, 16'd10);
    write_reg(REG_DERIV_ALPHA, 16'hFFFF);
    reg_settings++;
    push_sample(0, 5000, CMD_STEP);
    push_sample(0, 0, CMD_STEP);
    wait_idle();

    // widest dead zone and band: full-scale error is neither zeroed nor integrated
    write_reg(REG_DEAD_ZONE, 16'hFFFF);
    write_reg(REG_INTEGRAL_BAND, 16'hFFFF);
    reg_settings++;
    push_sample(-32768, 32767, CMD_STEP);
    push_sample(100, 200, CMD_STEP);
    wait_idle();

    // random phases, each with its own register setting
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph < 4) begin
        tx_idle_pct = 34;
        rx_idle_pct = 77;
      end else if (ph < 9) begin
        tx_idle_pct = 77;
        rx_idle_pct = 34;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if (ph == 0)
        program_regs(16'h7FFF, 16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000,
                     16'd3);
      else if (ph == RAND_PHASES - 1)
        program_regs(16'h8000, 16'h0001, 16'h0001, 16'h0000, 16'h8000, 16'h0001, 16'h0001,
                     16'h0100);
      else
        program_regs(rand_gain(), rand_gain(), rand_gain(), rand_limit(), rand_limit(),
                     rand_band(), rand_dead(), rand_alpha());
      for (int k = 0; k < PHASE_ITEMS; k++) pending_samples.push_back(rand_sample());
      wait_idle();
    end

    repeat (30) @(posedge clk_i);

    $display("Ran %0d samples (%0d clears) over %0d register settings, %0d drive values checked.",
             samples_in, clears_in, reg_settings, drives_seen);
    $display("Input stall cycles seen: %0d; mismatches: %0d.", input_stalls, mismatches);
    if (mismatches == 0 && expected_drive.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
